FILE: hdl/tbcd_pkg.sv
// Package: shared types, codes and default sizes of the tagged byte channel demux.
package tbcd_pkg;

	// Default configuration
	localparam int DEF_RING_DEPTH = 64;
	localparam int DEF_CHANNELS   = 2;

	// A tag byte carries TAG_BASE + channel
	localparam logic [7:0] TAG_BASE = 8'd127;

	// Operation codes
	localparam logic OP_RECEIVE = 1'b0;
	localparam logic OP_READ    = 1'b1;

	// Status codes
	localparam logic [2:0] ST_TAG          = 3'd0;
	localparam logic [2:0] ST_STORED       = 3'd1;
	localparam logic [2:0] ST_SKIPPED      = 3'd2;
	localparam logic [2:0] ST_LINE_ERR     = 3'd3;
	localparam logic [2:0] ST_OVERFLOW     = 3'd4;
	localparam logic [2:0] ST_EMPTY        = 3'd5;
	localparam logic [2:0] ST_BADTAG_OR_OK = 3'd6;

	// Input transaction
	typedef struct packed {
		logic       operation;
		logic [7:0] line_byte;
		logic       line_error;
		logic       read_channel;
	} in_item_t;

	// Output transaction
	typedef struct packed {
		logic [7:0] read_data;
		logic [2:0] status;
		logic       read_valid;
	} out_item_t;

	// Ring memory access strobes
	typedef struct packed {
		logic we;
		logic re;
	} mem_ctl_t;

	// Per-item outcome handed from the control to the output pipeline
	typedef struct packed {
		logic [2:0] status;
		logic       pop;
	} item_res_t;

endpackage

FILE: hdl/tagged_byte_channel_demux_unit.sv
// Top level: tagged byte channel demux with request decode, ring RAM and output stage.
//
// A serial byte stream is split into per-channel rings. On the request channel,
// operation RECEIVE hands one line byte: a tag byte 127 + channel arms the
// channel, the next byte is stored in its ring; bytes below 127 are skipped
// while hunting, a line error drops the pending pair. Operation READ pops the
// oldest byte of read_channel. Every request yields exactly one result
// transaction with read_data, status and read_valid.
// Timing: decode and the RAM read happen at the accept edge, into stage 1; the
// result then moves into the output register and is held until it is taken.
// Throughput: one request per cycle while the output is not stalled; the ring
// RAM has one port and each request uses it at most once, in its accept cycle.
// Reset clears the tag hunt state and all ring pointers, so every ring reads
// empty; ring contents are not cleared and no clearing pass is needed.
// When result_ready is held low, the output register and the one stage
// behind it fill, then request_ready drops until the output is taken.
module tagged_byte_channel_demux_unit import tbcd_pkg::*; #(
	parameter int RING_DEPTH = DEF_RING_DEPTH,
	parameter int CHANNELS   = DEF_CHANNELS
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      request_valid,
	output logic      request_ready,
	input  in_item_t  request,
	output logic      result_valid,
	input  logic      result_ready,
	output out_item_t result
);

	localparam int DEPTH = CHANNELS * RING_DEPTH;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic          accept, s1_adv;
	mem_ctl_t      mem_ctl;
	logic [AW-1:0] mem_addr;
	logic [7:0]    mem_rdata;
	item_res_t     res;

	logic       valid_s1;
	item_res_t  res_s1;
	logic       out_valid_q;
	out_item_t  out_q;

	// Handshake: stage 1 moves when the output register is free or draining
	assign s1_adv        = valid_s1 && (!out_valid_q || result_ready);
	assign request_ready = !valid_s1 || s1_adv;
	assign accept        = request_valid && request_ready;

	tbcd_ctrl #(
		.RING_DEPTH(RING_DEPTH),
		.CHANNELS  (CHANNELS),
		.AW        (AW)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.item    (request),
		.mem_ctl (mem_ctl),
		.mem_addr(mem_addr),
		.res     (res)
	);

	tbcd_ring_ram #(
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_ram (
		.clk  (clk),
		.ctl  (mem_ctl),
		.addr (mem_addr),
		.wdata(request.line_byte),
		.rdata(mem_rdata)
	);

	// Stage 1: outcome waits for RAM read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1 <= res;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_q.read_data  <= res_s1.pop ? mem_rdata : 8'd0;
			out_q.status     <= res_s1.status;
			out_q.read_valid <= res_s1.pop;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

	// A popped byte always carries the read-ok status
	a_pop_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.read_valid |-> out_q.status == ST_BADTAG_OR_OK)
		else $error("popped byte with wrong status");

	// Data field is zero unless a byte was popped
	a_zero_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_q.read_valid |-> out_q.read_data == 8'd0)
		else $error("nonzero read_data without a pop");

	// Requests are only held off while stage 1 is stuck behind a full output
	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!request_ready |-> valid_s1 && out_valid_q && !result_ready)
		else $error("request_ready low without a stalled output");

endmodule

FILE: hdl/tbcd_ring_ram.sv
// Ring storage: single-port synchronous RAM with registered read data.
module tbcd_ring_ram import tbcd_pkg::*; #(
	parameter int DEPTH = DEF_CHANNELS * DEF_RING_DEPTH,
	parameter int AW    = $clog2(DEF_CHANNELS * DEF_RING_DEPTH)
) (
	input  logic          clk,
	input  mem_ctl_t      ctl,
	input  logic [AW-1:0] addr,
	input  logic [7:0]    wdata,
	output logic [7:0]    rdata
);

	logic [7:0] mem [DEPTH];
	logic [7:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (ctl.we) begin
			mem[addr] <= wdata;
		end
	end

	// Read port, registered, holds between reads
	always_ff @(posedge clk) begin
		if (ctl.re) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: hdl/tbcd_ctrl.sv
// Control: tag hunt state, per-channel ring pointers and RAM request decode.
module tbcd_ctrl import tbcd_pkg::*; #(
	parameter int RING_DEPTH = DEF_RING_DEPTH,
	parameter int CHANNELS   = DEF_CHANNELS,
	parameter int AW         = $clog2(DEF_CHANNELS * DEF_RING_DEPTH)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          accept,
	input  in_item_t      item,
	output mem_ctl_t      mem_ctl,
	output logic [AW-1:0] mem_addr,
	output item_res_t     res
);

	localparam int PTR_W = $clog2(RING_DEPTH);
	localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);

	logic             awaiting_q;
	logic [CH_W-1:0]  pend_q;
	logic [PTR_W-1:0] wp_q [CHANNELS];
	logic [PTR_W-1:0] rp_q [CHANNELS];

	logic [CH_W-1:0]  ch;
	logic [PTR_W-1:0] wp_cur, rp_cur, wp_nx, rp_nx;
	logic [7:0]       tag_off;
	logic             tag_ok, rd_ch_ok;

	// Channel select and pointer lookups
	always_comb begin
		ch      = (item.operation == OP_READ) ? CH_W'(item.read_channel) : pend_q;
		wp_cur  = wp_q[ch];
		rp_cur  = rp_q[ch];
		wp_nx   = (wp_cur == PTR_LAST) ? '0 : wp_cur + 1'b1;
		rp_nx   = (rp_cur == PTR_LAST) ? '0 : rp_cur + 1'b1;
		tag_off = item.line_byte - TAG_BASE;
		tag_ok  = (item.line_byte >= TAG_BASE) && (9'(tag_off) < 9'(CHANNELS));
		rd_ch_ok = (9'(item.read_channel) < 9'(CHANNELS));
	end

	// Item decode: status, RAM strobe and address
	always_comb begin
		mem_ctl    = '0;
		mem_addr   = '0;
		res.status = ST_SKIPPED;
		res.pop    = 1'b0;
		if (item.operation == OP_READ) begin
			if (rd_ch_ok && (rp_cur != wp_cur)) begin
				mem_ctl.re = accept;
				mem_addr   = AW'(int'(ch) * RING_DEPTH + int'(rp_nx));
				res.status = ST_BADTAG_OR_OK;
				res.pop    = 1'b1;
			end else begin
				res.status = ST_EMPTY;
			end
		end else if (item.line_error) begin
			res.status = ST_LINE_ERR;
		end else if (awaiting_q) begin
			mem_ctl.we = accept;
			mem_addr   = AW'(int'(ch) * RING_DEPTH + int'(wp_nx));
			res.status = (wp_nx == rp_cur) ? ST_OVERFLOW : ST_STORED;
		end else if (item.line_byte < TAG_BASE) begin
			res.status = ST_SKIPPED;
		end else if (tag_ok) begin
			res.status = ST_TAG;
		end else begin
			res.status = ST_BADTAG_OR_OK;
		end
	end

	// State update on each accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			awaiting_q <= 1'b0;
			pend_q     <= '0;
			for (int i = 0; i < CHANNELS; i++) begin
				wp_q[i] <= '0;
				rp_q[i] <= '0;
			end
		end else if (accept) begin
			if (item.operation == OP_READ) begin
				if (res.pop) begin
					rp_q[ch] <= rp_nx;
				end
			end else if (item.line_error) begin
				awaiting_q <= 1'b0;
			end else if (awaiting_q) begin
				awaiting_q <= 1'b0;
				wp_q[ch]   <= wp_nx;
			end else if (tag_ok) begin
				awaiting_q <= 1'b1;
				pend_q     <= tag_off[CH_W-1:0];
			end
		end
	end

	// RAM is never written and read by the same transaction
	a_mem_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_ctl.we && mem_ctl.re))
		else $error("ring RAM write and read in the same cycle");

	// An accepted tag arms the data byte
	a_tag_arms: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (item.operation == OP_RECEIVE) && (res.status == ST_TAG) |=> awaiting_q)
		else $error("accepted tag did not arm data capture");

	// A store only happens while a data byte is awaited
	a_store_armed: assert property (@(posedge clk) disable iff (!arst_n)
		mem_ctl.we |-> awaiting_q && accept)
		else $error("ring store without a pending tag");

endmodule
